>>> rtl/core/actuator_command_safety_limiter_unit_assert.svh
// assertion macros for the actuator command safety limiter
`ifndef ACTUATOR_COMMAND_SAFETY_LIMITER_UNIT_ASSERT_SVH
`define ACTUATOR_COMMAND_SAFETY_LIMITER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define ACSL_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("acsl assertion failed");

`define ACSL_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("acsl assertion failed");

`else

`define ACSL_ASSERT_IMP(label, clk, rst_n, pre, post)

`define ACSL_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

>>> rtl/core/acsl_pkg.sv
package acsl_pkg;

  // fixed-point constants
  localparam logic [14:0]        ONE_Q14        = 15'd16384;
  localparam logic [14:0]        BRAKE_OVR_Q14  = 15'd1638;
  localparam logic signed [15:0] INTERLOCK_Q14  = 16'sd819;
  localparam logic [15:0]        LOW_SPEED_Q8   = 16'd512;
  localparam logic [14:0]        STEER_FLOOR    = 15'd409;
  localparam logic [14:0]        CAP_RESET      = 15'd4096;

  // divider geometry: quotient below 2^15, denominator below 2^33
  localparam int unsigned        DEN_W          = 33;
  localparam int unsigned        QUO_W          = 15;
  localparam int unsigned        DIV_STEPS      = QUO_W;
  localparam logic [DEN_W-1:0]   K_INV          = 33'd6553600;

  // stages: square, denominator, one per quotient bit, output
  localparam int unsigned        NSTG           = DIV_STEPS + 3;

  // configuration port
  localparam int unsigned        ADDR_W         = 3;
  localparam int unsigned        DATA_W         = 32;
  localparam logic [0:0]         REG_MAX_STEER  = 1'b0;

  typedef struct packed {
    logic signed [15:0] throttle_cmd;
    logic signed [15:0] brake_cmd;
    logic signed [15:0] steer_cmd;
    logic [15:0]        speed;
    logic               estop;
  } cmd_t;

  typedef struct packed {
    logic [14:0]        throttle_out;
    logic [14:0]        brake_out;
    logic signed [15:0] steer_cmd;
    logic               estop;
    logic               low_speed;
    logic               overridden;
    logic               conflict;
  } pay_t;

  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [14:0]        throttle_out;
    logic [14:0]        brake_out;
    logic signed [15:0] steer_out;
    logic               steer_limited;
    logic               throttle_overridden;
    logic               interlock_conflict;
  } res_t;

endpackage

>>> rtl/core/acsl_cmd_if.sv
interface acsl_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] throttle_cmd;
  logic signed [15:0] brake_cmd;
  logic signed [15:0] steer_cmd;
  logic [15:0]        speed;
  logic               estop;

  modport source (
    output valid, throttle_cmd, brake_cmd, steer_cmd, speed, estop,
    input  ready
  );

  modport sink (
    input  valid, throttle_cmd, brake_cmd, steer_cmd, speed, estop,
    output ready
  );
endinterface

>>> rtl/core/acsl_res_if.sv
interface acsl_res_if;
  logic               valid;
  logic               ready;
  logic [14:0]        throttle_out;
  logic [14:0]        brake_out;
  logic signed [15:0] steer_out;
  logic               steer_limited;
  logic               throttle_overridden;
  logic               interlock_conflict;

  modport source (
    output valid, throttle_out, brake_out, steer_out, steer_limited,
           throttle_overridden, interlock_conflict,
    input  ready
  );

  modport sink (
    input  valid, throttle_out, brake_out, steer_out, steer_limited,
           throttle_overridden, interlock_conflict,
    output ready
  );
endinterface

>>> rtl/core/acsl_front.sv
module acsl_front (
  input  logic                clk_i,
  input  logic                ld_a_i,
  input  logic                ld_b_i,
  input  logic [14:0]         cap_i,
  input  acsl_pkg::cmd_t      cmd_i,
  output acsl_pkg::pay_t      pay_o,
  output acsl_pkg::div_t      div_o
);

  logic [14:0]    thr_c;
  logic [14:0]    brk_c;
  logic           ovr;
  acsl_pkg::pay_t pay_a_d;
  acsl_pkg::pay_t pay_a_q;
  logic [31:0]    sq_q;
  acsl_pkg::pay_t pay_b_q;
  acsl_pkg::div_t div_b_d;
  acsl_pkg::div_t div_b_q;

  always_comb begin
    if (cmd_i.throttle_cmd < 0) begin
      thr_c = '0;
    end else if (cmd_i.throttle_cmd > $signed({1'b0, acsl_pkg::ONE_Q14})) begin
      thr_c = acsl_pkg::ONE_Q14;
    end else begin
      thr_c = cmd_i.throttle_cmd[14:0];
    end
    if (cmd_i.brake_cmd < 0) begin
      brk_c = '0;
    end else if (cmd_i.brake_cmd > $signed({1'b0, acsl_pkg::ONE_Q14})) begin
      brk_c = acsl_pkg::ONE_Q14;
    end else begin
      brk_c = cmd_i.brake_cmd[14:0];
    end
    ovr = !cmd_i.estop && (thr_c != '0) && (brk_c > acsl_pkg::BRAKE_OVR_Q14);

    pay_a_d.throttle_out = (cmd_i.estop || ovr) ? '0 : thr_c;
    pay_a_d.brake_out    = cmd_i.estop ? acsl_pkg::ONE_Q14 : brk_c;
    pay_a_d.steer_cmd    = cmd_i.steer_cmd;
    pay_a_d.estop        = cmd_i.estop;
    pay_a_d.low_speed    = cmd_i.speed <= acsl_pkg::LOW_SPEED_Q8;
    pay_a_d.overridden   = ovr;
    // interlock uses the raw commands, estop or not
    pay_a_d.conflict     = (cmd_i.throttle_cmd > acsl_pkg::INTERLOCK_Q14) &&
                           (cmd_i.brake_cmd > acsl_pkg::INTERLOCK_Q14);
  end

  // stage a: squarer
  always_ff @(posedge clk_i) begin
    if (ld_a_i) begin
      pay_a_q <= pay_a_d;
      sq_q    <= {16'b0, cmd_i.speed} * {16'b0, cmd_i.speed};
    end
  end

  // stage b: denominator and starting remainder
  // cap * 6553600 = (cap * 200) << 15, the low 15 numerator bits are zero
  always_comb begin
    div_b_d.den = acsl_pkg::K_INV + acsl_pkg::DEN_W'(sq_q);
    div_b_d.rem = acsl_pkg::DEN_W'({cap_i, 7'b0}) + acsl_pkg::DEN_W'({cap_i, 6'b0}) +
                  acsl_pkg::DEN_W'({cap_i, 3'b0});
    div_b_d.quo = '0;
  end

  always_ff @(posedge clk_i) begin
    if (ld_b_i) begin
      pay_b_q <= pay_a_q;
      div_b_q <= div_b_d;
    end
  end

  assign pay_o = pay_b_q;
  assign div_o = div_b_q;

endmodule

>>> rtl/core/acsl_div_stage.sv
module acsl_div_stage (
  input  logic           clk_i,
  input  logic           ld_i,
  input  acsl_pkg::pay_t pay_i,
  input  acsl_pkg::div_t div_i,
  output acsl_pkg::pay_t pay_o,
  output acsl_pkg::div_t div_o
);

  logic [acsl_pkg::DEN_W:0] trial;
  logic [acsl_pkg::DEN_W:0] diff;
  logic                     ge;
  acsl_pkg::div_t           div_d;
  acsl_pkg::div_t           div_q;
  acsl_pkg::pay_t           pay_q;

  // one restoring step; the numerator bit shifted in is always zero
  always_comb begin
    trial     = {div_i.rem, 1'b0};
    diff      = trial - {1'b0, div_i.den};
    ge        = trial >= {1'b0, div_i.den};
    div_d.den = div_i.den;
    div_d.rem = ge ? diff[acsl_pkg::DEN_W-1:0] : trial[acsl_pkg::DEN_W-1:0];
    div_d.quo = {div_i.quo[acsl_pkg::QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      div_q <= div_d;
      pay_q <= pay_i;
    end
  end

  assign div_o = div_q;
  assign pay_o = pay_q;

endmodule

>>> rtl/core/acsl_back.sv
module acsl_back (
  input  logic                       clk_i,
  input  logic                       ld_i,
  input  logic [14:0]                cap_i,
  input  acsl_pkg::pay_t             pay_i,
  input  logic [acsl_pkg::QUO_W-1:0] quo_i,
  output acsl_pkg::res_t             res_o
);

  logic [14:0]        lim;
  logic signed [16:0] str_x;
  logic signed [16:0] cap_x;
  logic [16:0]        mag;
  logic signed [15:0] lim_s;
  acsl_pkg::res_t     res_d;
  acsl_pkg::res_t     res_q;

  always_comb begin
    if (pay_i.low_speed) begin
      lim = cap_i;
    end else if (quo_i < acsl_pkg::STEER_FLOOR) begin
      lim = acsl_pkg::STEER_FLOOR;
    end else begin
      lim = quo_i;
    end
    str_x = 17'(pay_i.steer_cmd);
    cap_x = $signed({2'b0, cap_i});
    mag   = str_x[16] ? 17'(-str_x) : 17'(str_x);
    lim_s = $signed({1'b0, lim});

    res_d.throttle_out        = pay_i.throttle_out;
    res_d.brake_out           = pay_i.brake_out;
    res_d.throttle_overridden = pay_i.overridden;
    res_d.interlock_conflict  = pay_i.conflict;
    res_d.steer_limited       = 1'b0;
    if (pay_i.estop) begin
      res_d.steer_out = '0;
    end else if (mag > {2'b0, lim}) begin
      res_d.steer_out     = str_x[16] ? -lim_s : lim_s;
      res_d.steer_limited = 1'b1;
    end else if (str_x > cap_x) begin
      res_d.steer_out = $signed({1'b0, cap_i});
    end else if (str_x < -cap_x) begin
      res_d.steer_out = -$signed({1'b0, cap_i});
    end else begin
      res_d.steer_out = pay_i.steer_cmd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

>>> rtl/core/actuator_command_safety_limiter_unit.sv
// actuator command safety limiter
// cmd_i takes one vehicle command per beat (throttle, brake, steering, speed,
// estop); res_o gives exactly one safe command per accepted beat, in order.
// both channels are valid/ready; a beat moves when valid and ready are high.
// the steering cap is written through the apb port at address 0; the user must
// write it only while no command is in flight, as the block does not enforce it.
// pready is always high; reads with paddr[2] clear return the cap, others read 0.
// accepted commands pass through 18 register stages (squarer, denominator, 15
// restoring divider steps for the speed-dependent steering limit, output select).
// throughput: one command per cycle unless a stalled receiver has filled the
// pipeline; each divider step resolves one quotient bit, so the pipeline depth
// is set by the 15-bit quotient. a stalled receiver holds the output stage;
// earlier stages keep filling until every stage holds a beat, and cmd_i.ready
// drops only then. reset empties the pipeline and sets the cap to 0.5 rad.
`include "actuator_command_safety_limiter_unit_assert.svh"

module actuator_command_safety_limiter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  acsl_cmd_if.sink                      cmd_i,
  acsl_res_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [acsl_pkg::ADDR_W-1:0]   paddr,
  input  logic [acsl_pkg::DATA_W-1:0]   pwdata,
  output logic [acsl_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned NSTG = acsl_pkg::NSTG;
  localparam int unsigned NDIV = acsl_pkg::DIV_STEPS;

  logic [14:0]           cap_d;
  logic [14:0]           cap_q;
  logic                  reg_sel;
  logic [NSTG-1:0]       v_d;
  logic [NSTG-1:0]       v_q;
  logic [NSTG-1:0]       ld;
  acsl_pkg::cmd_t        cmd;
  acsl_pkg::pay_t        pay_s [NDIV+1];
  acsl_pkg::div_t        div_s [NDIV+1];
  acsl_pkg::res_t        res;

  // configuration
  assign reg_sel = paddr[acsl_pkg::ADDR_W-1:2] == acsl_pkg::REG_MAX_STEER;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? acsl_pkg::DATA_W'(cap_q) : '0;

  always_comb begin
    cap_d = cap_q;
    if (psel && penable && pwrite && reg_sel) begin
      cap_d = pwdata[14:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= acsl_pkg::CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  // a stage loads when it or any stage after it is empty, or the output drains
  for (genvar k = 0; k < NSTG; k++) begin : g_ld
    assign ld[k] = res_o.ready || !(&v_q[NSTG-1:k]);
  end

  always_comb begin
    v_d = v_q;
    if (ld[0]) begin
      v_d[0] = cmd_i.valid;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (ld[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign cmd_i.ready = ld[0];

  assign cmd.throttle_cmd = cmd_i.throttle_cmd;
  assign cmd.brake_cmd    = cmd_i.brake_cmd;
  assign cmd.steer_cmd    = cmd_i.steer_cmd;
  assign cmd.speed        = cmd_i.speed;
  assign cmd.estop        = cmd_i.estop;

  acsl_front u_front (
    .clk_i  (clk_i),
    .ld_a_i (ld[0]),
    .ld_b_i (ld[1]),
    .cap_i  (cap_q),
    .cmd_i  (cmd),
    .pay_o  (pay_s[0]),
    .div_o  (div_s[0])
  );

  for (genvar i = 0; i < NDIV; i++) begin : g_div
    acsl_div_stage u_div (
      .clk_i (clk_i),
      .ld_i  (ld[i+2]),
      .pay_i (pay_s[i]),
      .div_i (div_s[i]),
      .pay_o (pay_s[i+1]),
      .div_o (div_s[i+1])
    );
  end

  acsl_back u_back (
    .clk_i (clk_i),
    .ld_i  (ld[NSTG-1]),
    .cap_i (cap_q),
    .pay_i (pay_s[NDIV]),
    .quo_i (div_s[NDIV].quo),
    .res_o (res)
  );

  assign res_o.valid               = v_q[NSTG-1];
  assign res_o.throttle_out        = res.throttle_out;
  assign res_o.brake_out           = res.brake_out;
  assign res_o.steer_out           = res.steer_out;
  assign res_o.steer_limited       = res.steer_limited;
  assign res_o.throttle_overridden = res.throttle_overridden;
  assign res_o.interlock_conflict  = res.interlock_conflict;

  `ACSL_ASSERT_NEXT(a_enter, clk_i, rst_ni, cmd_i.valid && cmd_i.ready, v_q[0])
  `ACSL_ASSERT_NEXT(a_hold, clk_i, rst_ni, v_q[2] && !ld[3], v_q[2])
  `ACSL_ASSERT_IMP(a_rem_lt_den, clk_i, rst_ni, v_q[2], div_s[1].rem < div_s[1].den)
  `ACSL_ASSERT_IMP(a_quo_le_cap, clk_i, rst_ni, v_q[NSTG-2], div_s[NDIV].quo <= cap_q)

endmodule

>>> bench/actuator_command_safety_limiter_unit_tb.sv
module actuator_command_safety_limiter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              UNIT_Q14       = 16384;
  localparam int              OVERRIDE_Q14   = 1638;
  localparam int              CONFLICT_Q14   = 819;
  localparam int              LOW_SPEED_Q8   = 512;
  localparam int              STEER_MIN_Q13  = 409;
  localparam longint unsigned SPEED_K        = 64'd6553600;
  localparam int              PIPE_LATENCY   = 17;
  localparam logic [14:0]     CAP_AT_RESET   = 15'd4096;
  localparam logic [acsl_pkg::ADDR_W-1:0] REG_STEER_CAP = '0;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [acsl_pkg::ADDR_W-1:0]   paddr;
  logic [acsl_pkg::DATA_W-1:0]   pwdata;
  logic [acsl_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  acsl_cmd_if cmd_bus ();
  acsl_res_if res_bus ();

  actuator_command_safety_limiter_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_bus),
    .res_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  acsl_pkg::res_t safe_cmd_q[$];
  logic [14:0]    cap_model = CAP_AT_RESET;
  int             mismatch_count = 0;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;

  // speed-dependent steering bound, floor applied above low speed
  function automatic int steer_bound_of(input logic [15:0] spd, input logic [14:0] cap);
    longint unsigned q;
    if (int'(spd) <= LOW_SPEED_Q8) return int'(cap);
    q = (64'(cap) * SPEED_K) / (SPEED_K + 64'(spd) * 64'(spd));
    if (q < longint'(STEER_MIN_Q13)) q = 64'(STEER_MIN_Q13);
    return int'(q);
  endfunction

  function automatic acsl_pkg::res_t limit_command(input acsl_pkg::cmd_t c,
                                                   input logic [14:0] cap);
    acsl_pkg::res_t r;
    int thr, brk, str, t, b, s, lim, mag, capi;
    r    = '0;
    thr  = int'($signed(c.throttle_cmd));
    brk  = int'($signed(c.brake_cmd));
    str  = int'($signed(c.steer_cmd));
    capi = int'(cap);
    r.interlock_conflict = (thr > CONFLICT_Q14) && (brk > CONFLICT_Q14);
    if (c.estop) begin
      r.brake_out = 15'(UNIT_Q14);
    end else begin
      t = thr < 0 ? 0 : (thr > UNIT_Q14 ? UNIT_Q14 : thr);
      b = brk < 0 ? 0 : (brk > UNIT_Q14 ? UNIT_Q14 : brk);
      if (t > 0 && b > OVERRIDE_Q14) begin
        t = 0;
        r.throttle_overridden = 1'b1;
      end
      lim = steer_bound_of(c.speed, cap);
      mag = str < 0 ? -str : str;
      if (mag > lim) begin
        s = str < 0 ? -lim : lim;
        r.steer_limited = 1'b1;
      end else if (str > capi) begin
        s = capi;
      end else if (str < -capi) begin
        s = -capi;
      end else begin
        s = str;
      end
      r.throttle_out = 15'(t);
      r.brake_out    = 15'(b);
      r.steer_out    = 16'(s);
    end
    return r;
  endfunction

  function automatic logic [15:0] around(input int center, input int spread);
    return 16'(center - spread + int'($urandom_range(2 * spread)));
  endfunction

  function automatic logic [15:0] maybe_negated(input logic [15:0] v);
    if ($urandom_range(1)) return 16'(-int'($signed(v)));
    return v;
  endfunction

  function automatic acsl_pkg::cmd_t random_command();
    acsl_pkg::cmd_t c;
    int lim;
    case ($urandom_range(3))
      0: c.throttle_cmd = 16'($urandom);
      1: c.throttle_cmd = around(CONFLICT_Q14, 3);
      2: c.throttle_cmd = around(UNIT_Q14, 3);
      default: c.throttle_cmd = 16'($urandom_range(UNIT_Q14));
    endcase
    case ($urandom_range(4))
      0: c.brake_cmd = 16'($urandom);
      1: c.brake_cmd = around(CONFLICT_Q14, 3);
      2: c.brake_cmd = around(OVERRIDE_Q14, 3);
      3: c.brake_cmd = around(UNIT_Q14, 3);
      default: c.brake_cmd = 16'($urandom_range(UNIT_Q14));
    endcase
    case ($urandom_range(3))
      0: c.speed = 16'($urandom);
      1: c.speed = 16'($urandom_range(LOW_SPEED_Q8));
      2: c.speed = around(LOW_SPEED_Q8, 4);
      default: c.speed = 16'($urandom_range(4000, LOW_SPEED_Q8 + 1));
    endcase
    c.estop = ($urandom_range(9) == 0);
    lim = steer_bound_of(c.speed, cap_model);
    case ($urandom_range(4))
      0: c.steer_cmd = 16'($urandom);
      1: c.steer_cmd = maybe_negated(around(lim, 2));
      2: c.steer_cmd = maybe_negated(around(int'(cap_model), 2));
      3: c.steer_cmd = maybe_negated(around(STEER_MIN_Q13, 2));
      default: c.steer_cmd = maybe_negated(16'($urandom_range(lim)));
    endcase
    return c;
  endfunction

  // one command beat, with random idle cycles ahead of it
  task automatic send_command(input acsl_pkg::cmd_t c);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    cmd_bus.valid        = 1'b1;
    cmd_bus.throttle_cmd = c.throttle_cmd;
    cmd_bus.brake_cmd    = c.brake_cmd;
    cmd_bus.steer_cmd    = c.steer_cmd;
    cmd_bus.speed        = c.speed;
    cmd_bus.estop        = c.estop;
    do @(posedge clk_i); while (!cmd_bus.ready);
    safe_cmd_q.push_back(limit_command(c, cap_model));
  endtask

  task automatic send_fields(input int thr, input int brk, input int str,
                             input int spd, input bit stop);
    acsl_pkg::cmd_t c;
    c.throttle_cmd = 16'(thr);
    c.brake_cmd    = 16'(brk);
    c.steer_cmd    = 16'(str);
    c.speed        = 16'(spd);
    c.estop        = stop;
    send_command(c);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    cmd_bus.valid = 1'b0;
    while (safe_cmd_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 3) @(posedge clk_i);
  endtask

  task automatic write_steer_cap(input logic [31:0] word);
    drain_results();
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = REG_STEER_CAP;
    pwdata  = word;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    cap_model = word[14:0];
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // receiver back-pressure
  always @(negedge clk_i) begin
    res_bus.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    acsl_pkg::res_t exp_r;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (safe_cmd_q.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result beat: thr=%0d brk=%0d str=%0d",
                   res_bus.throttle_out, res_bus.brake_out, res_bus.steer_out);
        mismatch_count++;
      end else begin
        exp_r = safe_cmd_q.pop_front();
        if (res_bus.throttle_out !== exp_r.throttle_out ||
            res_bus.brake_out !== exp_r.brake_out ||
            res_bus.steer_out !== exp_r.steer_out ||
            res_bus.steer_limited !== exp_r.steer_limited ||
            res_bus.throttle_overridden !== exp_r.throttle_overridden ||
            res_bus.interlock_conflict !== exp_r.interlock_conflict) begin
          if (mismatch_count < 10)
            $display("mismatch: exp %0d/%0d/%0d %b%b%b got %0d/%0d/%0d %b%b%b",
                     exp_r.throttle_out, exp_r.brake_out, exp_r.steer_out,
                     exp_r.steer_limited, exp_r.throttle_overridden,
                     exp_r.interlock_conflict, res_bus.throttle_out,
                     res_bus.brake_out, res_bus.steer_out, res_bus.steer_limited,
                     res_bus.throttle_overridden, res_bus.interlock_conflict);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_directed_reset_cap();
    send_fields(0, 0, 0, 0, 0);
    send_fields(32767, -32768, 32767, 65535, 0);
    send_fields(-32768, 32767, -32768, 0, 0);
    // estop keeps the raw interlock flag
    send_fields(16384, 16384, 3000, 1000, 1);
    send_fields(32767, 32767, -32768, 65535, 1);
    send_fields(820, 820, 0, 0, 0);
    send_fields(819, 820, 0, 0, 0);
    send_fields(100, 1638, 0, 0, 0);
    send_fields(100, 1639, 0, 0, 0);
    send_fields(0, 5000, 0, 0, 0);
    send_fields(16385, 16384, 0, 0, 0);
    // low speed edge: bound is the cap itself
    send_fields(2000, 0, 4097, 512, 0);
    send_fields(2000, 0, -4096, 512, 0);
    send_fields(2000, 0, 4000, 513, 0);
    send_fields(0, 0, -20000, 3000, 0);
    send_fields(0, 0, -32768, 100, 0);
  endtask

  task automatic test_directed_small_cap();
    write_steer_cap(32'd100);
    // floor above cap: within floor clamps to cap, beyond takes floor
    send_fields(0, 0, 300, 65535, 0);
    send_fields(0, 0, 500, 65535, 0);
    send_fields(0, 0, -300, 65535, 0);
    send_fields(0, 0, -32768, 65535, 0);
    write_steer_cap(32'd0);
    send_fields(0, 0, 1, 0, 0);
    send_fields(0, 0, 409, 700, 0);
  endtask

  task automatic test_directed_full_cap();
    write_steer_cap(32'h0000_7fff);
    send_fields(0, 0, -32768, 0, 0);
    send_fields(0, 0, 32767, 600, 0);
    send_fields(0, 0, -32767, 65535, 0);
  endtask

  // sender holds off once until the pipeline has emptied
  task automatic test_pause_drain();
    send_idle_pct = 19;
    recv_idle_pct = 59;
    write_steer_cap(32'(CAP_AT_RESET));
    repeat (30) send_command(random_command());
    drain_results();
    repeat (30) send_command(random_command());
  endtask

  task automatic test_random_traffic(input int sidle, input int ridle,
                                     input int chunks, input int per_chunk);
    logic [31:0] word;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int k = 0; k < chunks; k++) begin
      case (k % 4)
        0: word = 32'h0000_7fff;
        1: word = 32'h0;
        2: word = 32'($urandom_range(500, 300));
        default: word = $urandom;
      endcase
      write_steer_cap(word);
      repeat (per_chunk) send_command(random_command());
    end
  endtask

  initial begin
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    cmd_bus.valid        = 1'b0;
    cmd_bus.throttle_cmd = '0;
    cmd_bus.brake_cmd    = '0;
    cmd_bus.steer_cmd    = '0;
    cmd_bus.speed        = '0;
    cmd_bus.estop        = 1'b0;
    res_bus.ready        = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 19;
    recv_idle_pct = 59;
    test_directed_reset_cap();
    test_directed_small_cap();
    test_directed_full_cap();
    test_pause_drain();
    test_random_traffic(19, 59, 4, 135);
    test_random_traffic(59, 19, 4, 135);
    test_random_traffic(0, 0, 4, 135);

    drain_results();
    if (mismatch_count == 0 && safe_cmd_q.size() == 0) begin
      $display("actuator_command_safety_limiter_unit_tb passed");
    end else begin
      $display("actuator_command_safety_limiter_unit_tb failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("actuator_command_safety_limiter_unit_tb failed");
    $finish;
  end

endmodule
